### rtl/mfa256_pkg.sv
// Shared types, operation codes and widths for the 256-bit Montgomery field ALU.
package mfa256_pkg;

    localparam int WORD_W = 64;
    localparam int NUM_WORDS = 4;
    localparam int FIELD_W = WORD_W * NUM_WORDS;
    localparam int ACC_W = FIELD_W * 2 + WORD_W;

    localparam logic [3:0] KIND_ADD = 4'd0;
    localparam logic [3:0] KIND_SUB = 4'd1;
    localparam logic [3:0] KIND_DBL = 4'd2;
    localparam logic [3:0] KIND_TRI = 4'd3;
    localparam logic [3:0] KIND_NEG = 4'd4;
    localparam logic [3:0] KIND_MUL = 4'd5;
    localparam logic [3:0] KIND_SQR = 4'd6;
    localparam logic [3:0] KIND_HALF = 4'd7;
    localparam logic [3:0] KIND_FROM = 4'd8;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_TRI = 3'd2;
    localparam logic [2:0] OP_NEG = 3'd3;
    localparam logic [2:0] OP_MUL = 3'd4;
    localparam logic [2:0] OP_HALF = 3'd5;
    localparam logic [2:0] OP_FROM = 3'd6;
    localparam logic [2:0] OP_ZERO = 3'd7;

    localparam logic [2:0] REG_MOD0 = 3'd0;
    localparam logic [2:0] REG_MOD1 = 3'd1;
    localparam logic [2:0] REG_MOD2 = 3'd2;
    localparam logic [2:0] REG_MOD3 = 3'd3;
    localparam logic [2:0] REG_NINV = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
    } q_entry_t;

    typedef struct packed {
        logic       is_m;
        logic [2:0] off;
    } mul_tag_t;

endpackage

### rtl/montgomery_field_alu_256.sv
// Top level of the 256-bit Montgomery field ALU: register port, front, back.
//
// Command channel: drive kind and both operands with start high; the beat is
// taken at a clock edge where busy is low. A two-entry queue sits between the
// front end and the back end, so new commands are taken while the back end
// works; busy rises only when that queue is full.
// Result channel: result_valid is high for exactly one cycle with the four
// result words; the receiver cannot stall and must take the beat then.
// Results come out in command order, one per command.
// The single 64x64 multiplier, two stages deep, gets a word product a cycle,
// except where the word-serial reduction waits for it to drain before each
// word. The back end takes the next command as the result leaves; it takes
// no new command before it is through with the last one.
// Configuration: APB writes to modulus words 0..3 and the negated inverse,
// 64-bit registers at byte addresses 8*i; write only while idle.
// Reset clears the registers to zero, empties the queue and idles the back.
module montgomery_field_alu_256
    import mfa256_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic [3:0]        kind,
    input  logic [WORD_W-1:0] operand_a_word0,
    input  logic [WORD_W-1:0] operand_a_word1,
    input  logic [WORD_W-1:0] operand_a_word2,
    input  logic [WORD_W-1:0] operand_a_word3,
    input  logic [WORD_W-1:0] operand_b_word0,
    input  logic [WORD_W-1:0] operand_b_word1,
    input  logic [WORD_W-1:0] operand_b_word2,
    input  logic [WORD_W-1:0] operand_b_word3,
    output logic              result_valid,
    output logic [WORD_W-1:0] result_word0,
    output logic [WORD_W-1:0] result_word1,
    output logic [WORD_W-1:0] result_word2,
    output logic [WORD_W-1:0] result_word3
);

    logic [WORD_W-1:0]  mod_reg [NUM_WORDS];
    logic [WORD_W-1:0]  ninv_reg;
    logic               wr_en;
    logic [2:0]         reg_idx;
    logic               head_valid;
    q_entry_t           head;
    logic               pop;
    logic [FIELD_W-1:0] res;
    logic [FIELD_W-1:0] p;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[5:3];
    assign p       = {mod_reg[3], mod_reg[2], mod_reg[1], mod_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_WORDS; k++)
            begin
                mod_reg[k] <= '0;
            end
            ninv_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MOD0: mod_reg[0] <= pwdata;
                REG_MOD1: mod_reg[1] <= pwdata;
                REG_MOD2: mod_reg[2] <= pwdata;
                REG_MOD3: mod_reg[3] <= pwdata;
                REG_NINV: ninv_reg   <= pwdata;
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MOD0: prdata = mod_reg[0];
            REG_MOD1: prdata = mod_reg[1];
            REG_MOD2: prdata = mod_reg[2];
            REG_MOD3: prdata = mod_reg[3];
            REG_NINV: prdata = ninv_reg;
            default:  prdata = '0;
        endcase
    end

    mfa256_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .kind       (kind),
        .a          ({operand_a_word3, operand_a_word2, operand_a_word1, operand_a_word0}),
        .b          ({operand_b_word3, operand_b_word2, operand_b_word1, operand_b_word0}),
        .pop        (pop),
        .busy       (busy),
        .head_valid (head_valid),
        .head       (head)
    );

    mfa256_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .p          (p),
        .ninv       (ninv_reg),
        .res_valid  (result_valid),
        .res        (res)
    );

    assign result_word0 = res[63:0];
    assign result_word1 = res[127:64];
    assign result_word2 = res[191:128];
    assign result_word3 = res[255:192];

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("back end popped an empty queue");

    a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("results issued on consecutive cycles");

    a_busy_means_queued: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> head_valid)
        else $error("busy while queue holds nothing");

endmodule

### rtl/mfa256_front.sv
// Front end: classifies operation kinds and queues items for the back end.
module mfa256_front
    import mfa256_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [3:0]         kind,
    input  logic [FIELD_W-1:0] a,
    input  logic [FIELD_W-1:0] b,
    input  logic               pop,
    output logic               busy,
    output logic               head_valid,
    output q_entry_t           head
);

    q_entry_t   ent_reg [2];
    logic       rd_reg;
    logic       rd_next;
    logic       wr_reg;
    logic       wr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    q_entry_t   new_ent;

    always_comb
    begin
        new_ent.a = a;
        new_ent.b = b;
        unique case (kind)
            KIND_ADD:  new_ent.op = OP_ADD;
            KIND_SUB:  new_ent.op = OP_SUB;
            KIND_DBL:
            begin
                new_ent.op = OP_ADD;
                new_ent.b  = a;
            end
            KIND_TRI:  new_ent.op = OP_TRI;
            KIND_NEG:  new_ent.op = OP_NEG;
            KIND_MUL:  new_ent.op = OP_MUL;
            KIND_SQR:
            begin
                new_ent.op = OP_MUL;
                new_ent.b  = a;
            end
            KIND_HALF: new_ent.op = OP_HALF;
            KIND_FROM: new_ent.op = OP_FROM;
            default:   new_ent.op = OP_ZERO;
        endcase
    end

    assign busy       = (cnt_reg == 2'd2);
    assign push       = start && !busy;
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = ent_reg[rd_reg];

    always_comb
    begin
        rd_next  = pop ? ~rd_reg : rd_reg;
        wr_next  = push ? ~wr_reg : wr_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_reg] <= new_ent;
        end
    end

endmodule

### rtl/mfa256_mul.sv
// Two-stage 64x64 multiplier built from four 32x32 partial products.
module mfa256_mul
    import mfa256_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [WORD_W-1:0]   x,
    input  logic [WORD_W-1:0]   y,
    input  mul_tag_t            in_tag,
    output logic                out_valid,
    output logic [2*WORD_W-1:0] prod,
    output mul_tag_t            out_tag,
    output logic                pipe_busy
);

    logic                v1_reg;
    logic                v2_reg;
    mul_tag_t            tag1_reg;
    mul_tag_t            tag2_reg;
    logic [WORD_W-1:0]   pp00_reg;
    logic [WORD_W-1:0]   pp01_reg;
    logic [WORD_W-1:0]   pp10_reg;
    logic [WORD_W-1:0]   pp11_reg;
    logic [2*WORD_W-1:0] prod_reg;
    logic [2*WORD_W-1:0] prod_next;

    always_comb
    begin
        prod_next = {64'd0, pp00_reg}
                  + {32'd0, pp01_reg, 32'd0}
                  + {32'd0, pp10_reg, 32'd0}
                  + {pp11_reg, 64'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pp00_reg <= x[31:0] * y[31:0];
        pp01_reg <= x[31:0] * y[63:32];
        pp10_reg <= x[63:32] * y[31:0];
        pp11_reg <= x[63:32] * y[63:32];
        tag1_reg <= in_tag;
        prod_reg <= prod_next;
        tag2_reg <= tag1_reg;
    end

    assign out_valid = v2_reg;
    assign prod      = prod_reg;
    assign out_tag   = tag2_reg;
    assign pipe_busy = v1_reg || v2_reg;

endmodule

### rtl/mfa256_back.sv
// Back end: modular add, sub, neg, halve; word-serial Montgomery mul and reduce.
module mfa256_back
    import mfa256_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  q_entry_t           head,
    output logic               pop,
    input  logic [FIELD_W-1:0] p,
    input  logic [WORD_W-1:0]  ninv,
    output logic               res_valid,
    output logic [FIELD_W-1:0] res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADD   = 4'd1;
    localparam logic [3:0] S_AFIX  = 4'd2;
    localparam logic [3:0] S_SUB   = 4'd3;
    localparam logic [3:0] S_SFIX  = 4'd4;
    localparam logic [3:0] S_ONE   = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_MWAIT = 4'd7;
    localparam logic [3:0] S_MGET  = 4'd8;
    localparam logic [3:0] S_MP    = 4'd9;
    localparam logic [3:0] S_FWAIT = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0]          st_reg;
    logic [3:0]          st_next;
    logic [2:0]          op_reg;
    logic [2:0]          op_next;
    logic [FIELD_W-1:0]  a_reg;
    logic [FIELD_W-1:0]  a_next;
    logic [FIELD_W-1:0]  b_reg;
    logic [FIELD_W-1:0]  b_next;
    logic [FIELD_W:0]    x_reg;
    logic [FIELD_W:0]    x_next;
    logic [ACC_W-1:0]    t_reg;
    logic [ACC_W-1:0]    t_next;
    logic [WORD_W-1:0]   m_reg;
    logic [WORD_W-1:0]   m_next;
    logic [3:0]          cnt_reg;
    logic [3:0]          cnt_next;
    logic [1:0]          i_reg;
    logic [1:0]          i_next;
    logic                pass_reg;
    logic                pass_next;
    logic                rv_reg;
    logic                rv_next;
    logic [FIELD_W-1:0]  res_reg;
    logic [FIELD_W-1:0]  res_next;

    logic                mi_valid;
    logic [WORD_W-1:0]   mi_x;
    logic [WORD_W-1:0]   mi_y;
    mul_tag_t            mi_tag;
    logic                mo_valid;
    logic [2*WORD_W-1:0] mo_prod;
    mul_tag_t            mo_tag;
    logic                mul_busy;

    logic [FIELD_W-1:0]  xl;
    logic                x_fix;
    logic [FIELD_W-1:0]  fix_add;
    logic [FIELD_W-1:0]  fix_sub;
    logic [FIELD_W:0]    half_v;
    logic [FIELD_W-1:0]  one_res;
    logic [FIELD_W-1:0]  fin_r;
    logic                fin_fix;
    logic [FIELD_W-1:0]  fin_res;
    logic [ACC_W-1:0]    acc_add;

    mfa256_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mi_valid),
        .x         (mi_x),
        .y         (mi_y),
        .in_tag    (mi_tag),
        .out_valid (mo_valid),
        .prod      (mo_prod),
        .out_tag   (mo_tag),
        .pipe_busy (mul_busy)
    );

    always_comb
    begin
        xl      = x_reg[FIELD_W-1:0];
        x_fix   = x_reg[FIELD_W] || (xl >= p);
        fix_add = x_fix ? (xl - p) : xl;
        fix_sub = x_fix ? (xl + p) : xl;
        half_v  = a_reg[0] ? ({1'b0, a_reg} + {1'b0, p}) : {1'b0, a_reg};
        unique case (op_reg)
            OP_NEG:  one_res = (a_reg == '0) ? '0 : (p - a_reg);
            OP_HALF: one_res = half_v[FIELD_W:1];
            default: one_res = '0;
        endcase
        fin_r   = t_reg[2*FIELD_W-1:FIELD_W];
        fin_fix = (|t_reg[ACC_W-1:2*FIELD_W]) || (fin_r >= p);
        fin_res = fin_fix ? (fin_r - p) : fin_r;
        acc_add = {{(ACC_W-2*WORD_W){1'b0}}, mo_prod} << {mo_tag.off, 6'd0};
    end

    always_comb
    begin
        st_next   = st_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        x_next    = x_reg;
        t_next    = t_reg;
        m_next    = m_reg;
        cnt_next  = cnt_reg;
        i_next    = i_reg;
        pass_next = pass_reg;
        rv_next   = 1'b0;
        res_next  = res_reg;
        pop       = 1'b0;
        mi_valid  = 1'b0;
        mi_x      = a_reg[{cnt_reg[3:2], 6'd0} +: WORD_W];
        mi_y      = b_reg[{cnt_reg[1:0], 6'd0} +: WORD_W];
        mi_tag.is_m = 1'b0;
        mi_tag.off  = {1'b0, cnt_reg[3:2]} + {1'b0, cnt_reg[1:0]};

        if (mo_valid && !mo_tag.is_m)
        begin
            t_next = t_reg + acc_add;
        end
        if (mo_valid && mo_tag.is_m)
        begin
            m_next = mo_prod[WORD_W-1:0];
        end

        unique case (st_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop       = 1'b1;
                    op_next   = head.op;
                    a_next    = head.a;
                    b_next    = head.b;
                    pass_next = 1'b0;
                    cnt_next  = 4'd0;
                    i_next    = 2'd0;
                    unique case (head.op)
                        OP_ADD:  st_next = S_ADD;
                        OP_TRI:
                        begin
                            b_next  = head.a;
                            st_next = S_ADD;
                        end
                        OP_SUB:  st_next = S_SUB;
                        OP_MUL:
                        begin
                            t_next  = '0;
                            st_next = S_MUL;
                        end
                        OP_FROM:
                        begin
                            t_next  = {{(ACC_W-FIELD_W){1'b0}}, head.a};
                            st_next = S_MWAIT;
                        end
                        default: st_next = S_ONE;
                    endcase
                end
            end
            S_ADD:
            begin
                x_next  = {1'b0, a_reg} + {1'b0, b_reg};
                st_next = S_AFIX;
            end
            S_AFIX:
            begin
                if (op_reg == OP_TRI && !pass_reg)
                begin
                    b_next    = fix_add;
                    pass_next = 1'b1;
                    st_next   = S_ADD;
                end
                else
                begin
                    rv_next  = 1'b1;
                    res_next = fix_add;
                    st_next  = S_IDLE;
                end
            end
            S_SUB:
            begin
                x_next  = {1'b0, a_reg} - {1'b0, b_reg};
                st_next = S_SFIX;
            end
            S_SFIX:
            begin
                rv_next  = 1'b1;
                res_next = fix_sub;
                st_next  = S_IDLE;
            end
            S_ONE:
            begin
                rv_next  = 1'b1;
                res_next = one_res;
                st_next  = S_IDLE;
            end
            S_MUL:
            begin
                mi_valid = 1'b1;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    st_next = S_MWAIT;
                end
            end
            S_MWAIT:
            begin
                mi_x        = t_reg[{i_reg, 6'd0} +: WORD_W];
                mi_y        = ninv;
                mi_tag.is_m = 1'b1;
                if (!mul_busy)
                begin
                    mi_valid = 1'b1;
                    st_next  = S_MGET;
                end
            end
            S_MGET:
            begin
                if (mo_valid && mo_tag.is_m)
                begin
                    cnt_next = 4'd0;
                    st_next  = S_MP;
                end
            end
            S_MP:
            begin
                mi_valid   = 1'b1;
                mi_x       = p[{cnt_reg[1:0], 6'd0} +: WORD_W];
                mi_y       = m_reg;
                mi_tag.off = {1'b0, i_reg} + {1'b0, cnt_reg[1:0]};
                cnt_next   = cnt_reg + 4'd1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    i_next  = i_reg + 2'd1;
                    st_next = (i_reg == 2'd3) ? S_FWAIT : S_MWAIT;
                end
            end
            S_FWAIT:
            begin
                if (!mul_busy && !mo_valid)
                begin
                    st_next = S_FIN;
                end
            end
            S_FIN:
            begin
                rv_next  = 1'b1;
                res_next = fin_res;
                st_next  = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            rv_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            rv_reg <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        x_reg    <= x_next;
        t_reg    <= t_next;
        m_reg    <= m_next;
        cnt_reg  <= cnt_next;
        i_reg    <= i_next;
        pass_reg <= pass_next;
        res_reg  <= res_next;
    end

    assign res_valid = rv_reg;
    assign res       = res_reg;

endmodule
